// ----- src/ptor_pkg.sv -----
package ptor_pkg;

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_PRUNE = 2'd1,
    OP_GET   = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_UPDATED  = 3'd0,
    ST_APPENDED = 3'd1,
    ST_REPLACED = 3'd2,
    ST_IGNORED  = 3'd3,
    ST_PRUNED   = 3'd4,
    ST_PEER     = 3'd5
  } status_e;

  localparam logic CFG_MAX_PEERS = 1'b0;
  localparam logic CFG_MAX_AGE   = 1'b1;
  localparam int unsigned GET_LIMIT = 64;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] peer_addr;
    logic [15:0] peer_port;
    logic [31:0] now_seconds;
    logic [7:0]  window_start;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        has_peer;
    logic [31:0] out_addr;
    logic [15:0] out_port;
    logic [7:0]  entry_count;
    logic        last_of_run;
  } out_item_t;

  typedef struct packed {
    logic [31:0] addr;
    logic [15:0] port;
    logic [31:0] seen;
  } entry_t;

endpackage

// ----- src/ptor_if.sv -----
interface ptor_in_if;
  logic                valid;
  logic                ready;
  ptor_pkg::in_item_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface ptor_out_if;
  logic                valid;
  logic                ready;
  ptor_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- src/ptor_mem.sv -----
module ptor_mem #(
  parameter int unsigned AW = 7
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [AW-1:0]     waddr_i,
  input  ptor_pkg::entry_t  wdata_i,
  input  logic [AW-1:0]     raddr_i,
  output ptor_pkg::entry_t  rdata_o
);
  ptor_pkg::entry_t mem_q [2**AW];

  // one write port and one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ----- src/peer_table_oldest_replace.sv -----
// Peer table of TABLE_DEPTH entries held in one synchronous memory. Add and
// prune walk the stored entries one per cycle. An item passes through the
// accept, the walk, the drain of the read pipeline, the write back or commit
// of the count, and the load of the result. An add that hits stops the walk
// early. Ignored adds and unknown ops go straight to the result load. Get
// sets up its window and then emits each entry as a read, then a result
// load, and issues a read only while the output register is free. Prune
// compacts in place: the write pointer never passes the read pointer. One
// item is worked at a time; each result waits in an output register and
// stalls the block until it is taken, and the next item is taken in the cycle
// the last result of the previous one is consumed.
module peer_table_oldest_replace #(
  parameter int unsigned TABLE_DEPTH = 128
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  ptor_in_if.sink     in_if,
  ptor_out_if.source  out_if
);
  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = AW + 1;
  localparam int unsigned NW = (CW > 8) ? CW : 8;
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SCAN  = 6'b000010,
    S_FIN   = 6'b000100,
    S_GETW  = 6'b001000,
    S_GET   = 6'b010000,
    S_OUT   = 6'b100000
  } state_e;

  state_e              state_q, state_d;
  logic [6:0]          max_peers_q;
  logic [31:0]         max_age_q;
  logic [CW-1:0]       fill_q, fill_d;
  ptor_pkg::in_item_t  item_q;
  logic [CW-1:0]       rptr_q, rptr_d;   // address issued to read port
  logic [CW-1:0]       wptr_q, wptr_d;   // prune keep count
  logic                rv_q, rv_d;       // read data valid this cycle
  logic [CW-1:0]       ridx_q, ridx_d;   // index of read data
  logic [CW-1:0]       left_q, left_d;   // get entries still to issue
  logic [6:0]          sent_q, sent_d;   // get entries remaining to emit
  logic                found_q, found_d;
  logic [AW-1:0]       hit_q, hit_d;
  logic [AW-1:0]       old_q, old_d;
  logic [31:0]         least_q, least_d;
  logic [31:0]         limit_q;
  logic                ov_q, ov_d;
  ptor_pkg::out_item_t od_q, od_d;
  logic                appended_q;
  logic                we;
  logic [AW-1:0]       waddr;
  ptor_pkg::entry_t    wdata, rdata;
  logic [AW-1:0]       raddr;
  logic [6:0]          mp;
  logic [NW-1:0]       mp_w, fill_w, top_w, ws_w, start_w;
  logic                out_free;

  ptor_mem #(.AW(AW)) u_mem (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  assign out_free     = !ov_q || out_if.ready;
  assign in_if.ready  = (state_q == S_IDLE) && out_free;
  assign out_if.valid = ov_q;
  assign out_if.data  = od_q;
  assign raddr        = rptr_q[AW-1:0];

  // clamped window size and start
  always_comb begin
    mp = max_peers_q;
    if (mp == 7'd0) mp = 7'd1;
    if (mp > 7'(ptor_pkg::GET_LIMIT)) mp = 7'(ptor_pkg::GET_LIMIT);
    mp_w    = NW'(mp);
    fill_w  = NW'(fill_q);
    top_w   = fill_w - mp_w - NW'(1);
    ws_w    = NW'(item_q.window_start);
    start_w = (ws_w < top_w) ? ws_w : top_w;
  end

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_peers_q <= 7'd30;
      max_age_q   <= 32'd1800;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ptor_pkg::CFG_MAX_PEERS: max_peers_q <= cfg_data_i[6:0];
        ptor_pkg::CFG_MAX_AGE:   max_age_q   <= cfg_data_i;
      endcase
    end
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    fill_d  = fill_q;
    rptr_d  = rptr_q;
    wptr_d  = wptr_q;
    rv_d    = 1'b0;
    ridx_d  = rptr_q;
    left_d  = left_q;
    sent_d  = sent_q;
    found_d = found_q;
    hit_d   = hit_q;
    old_d   = old_q;
    least_d = least_q;
    ov_d    = ov_q && !out_if.ready;
    od_d    = od_q;
    we      = 1'b0;
    waddr   = '0;
    wdata   = '{addr: item_q.peer_addr, port: item_q.peer_port,
                seen: item_q.now_seconds};
    unique case (state_q)
      S_IDLE: begin
        if (in_if.valid && in_if.ready) begin
          rptr_d  = '0;
          wptr_d  = '0;
          found_d = 1'b0;
          least_d = '1;
          old_d   = '0;
          if (in_if.data.op == ptor_pkg::OP_GET) state_d = S_GETW;
          else if (in_if.data.op == ptor_pkg::OP_ADD && in_if.data.peer_port == '0)
            state_d = S_OUT;
          else if (in_if.data.op == ptor_pkg::OP_NONE) state_d = S_OUT;
          else state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        // issue next read, check returned entry
        if (rptr_q < fill_q && !found_q) begin
          rptr_d = rptr_q + CW'(1);
          rv_d   = 1'b1;
        end
        if (rv_q) begin
          if (item_q.op == ptor_pkg::OP_ADD) begin
            if (!found_q && rdata.addr == item_q.peer_addr) begin
              found_d = 1'b1;
              hit_d   = ridx_q[AW-1:0];
            end else if (!found_q && rdata.seen < least_q) begin
              least_d = rdata.seen;
              old_d   = ridx_q[AW-1:0];
            end
          end else if (rdata.seen >= limit_q) begin
            we     = 1'b1;
            waddr  = wptr_q[AW-1:0];
            wdata  = rdata;
            wptr_d = wptr_q + CW'(1);
          end
        end
        if (!rv_q && !(rptr_q < fill_q && !found_q)) state_d = S_FIN;
      end
      S_FIN: begin
        state_d = S_OUT;
        if (item_q.op == ptor_pkg::OP_PRUNE) begin
          fill_d = wptr_q;
        end else begin
          we = 1'b1;
          if (found_q) waddr = hit_q;
          else if (fill_q < DEPTH_C) begin
            waddr  = fill_q[AW-1:0];
            fill_d = fill_q + CW'(1);
          end else waddr = old_q;
        end
      end
      S_GETW: begin
        if (fill_q == '0) state_d = S_OUT;
        else begin
          if (fill_w > mp_w) begin
            rptr_d = start_w[CW-1:0];
            left_d = mp_w[CW-1:0];
          end else begin
            rptr_d = '0;
            left_d = fill_q;
          end
          sent_d  = 7'(left_d);
          state_d = S_GET;
        end
      end
      S_GET: begin
        // issue reads while output path can absorb them
        if (rv_q) begin
          ov_d = 1'b1;
          od_d = '{status: ptor_pkg::ST_PEER, has_peer: 1'b1, out_addr: rdata.addr,
                   out_port: rdata.port, entry_count: 8'(fill_q),
                   last_of_run: sent_q == 7'd1};
          sent_d = sent_q - 7'd1;
          if (sent_q == 7'd1) state_d = S_IDLE;
        end
        if (left_q != '0 && !rv_q && !ov_d) begin
          rv_d   = 1'b1;
          left_d = left_q - CW'(1);
          rptr_d = rptr_q + CW'(1);
        end
      end
      S_OUT: begin
        if (out_free) begin
          ov_d    = 1'b1;
          state_d = S_IDLE;
          od_d    = '{status: ptor_pkg::ST_IGNORED, has_peer: 1'b0, out_addr: '0,
                      out_port: '0, entry_count: 8'(fill_q), last_of_run: 1'b1};
          if (item_q.op == ptor_pkg::OP_PRUNE) od_d.status = ptor_pkg::ST_PRUNED;
          else if (item_q.op == ptor_pkg::OP_GET) od_d.status = ptor_pkg::ST_PEER;
          else if (item_q.op == ptor_pkg::OP_ADD && item_q.peer_port != '0) begin
            if (found_q) od_d.status = ptor_pkg::ST_UPDATED;
            else od_d.status = appended_q ? ptor_pkg::ST_APPENDED
                                           : ptor_pkg::ST_REPLACED;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      fill_q     <= '0;
      ov_q       <= 1'b0;
      rv_q       <= 1'b0;
      appended_q <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      ov_q    <= ov_d;
      rv_q    <= rv_d;
      if (state_q == S_FIN) appended_q <= !found_q && fill_q < DEPTH_C;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_if.valid && in_if.ready) begin
      item_q  <= in_if.data;
      limit_q <= in_if.data.now_seconds - max_age_q;
    end
    rptr_q  <= rptr_d;
    wptr_q  <= wptr_d;
    ridx_q  <= ridx_d;
    left_q  <= left_d;
    sent_q  <= sent_d;
    found_q <= found_d;
    hit_q   <= hit_d;
    old_q   <= old_d;
    least_q <= least_d;
    od_q    <= od_d;
  end

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= DEPTH_C) else $error("fill count beyond depth");
  a_prune_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SCAN |-> wptr_q <= rptr_q) else $error("prune write passed read");
  a_busy_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != S_IDLE |-> !in_if.ready) else $error("ready while busy");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q && !out_if.ready |=> ov_q && $stable(od_q)) else $error("result dropped");
`endif
endmodule

// ----- tb/sv/ptor_checker.sv -----
module ptor_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [0:0]          cfg_idx_i,
  input  logic [31:0]         cfg_data_i,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  ptor_pkg::in_item_t  in_data_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  ptor_pkg::out_item_t out_data_i,
  output int                  fail_count_o,
  output int                  pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH = 128;

  // shadow copy of the table and registers
  ptor_pkg::entry_t    peer_tab [DEPTH];
  int unsigned         fill_cnt;
  logic [6:0]          max_peers_q;
  logic [31:0]         max_age_q;
  ptor_pkg::out_item_t expected_results [$];

  function automatic ptor_pkg::out_item_t make_result(ptor_pkg::status_e st, logic has,
                                                      ptor_pkg::entry_t e, logic last);
    ptor_pkg::out_item_t r;
    r.status      = st;
    r.has_peer    = has;
    r.out_addr    = has ? e.addr : 32'd0;
    r.out_port    = has ? e.port : 16'd0;
    r.entry_count = fill_cnt[7:0];
    r.last_of_run = last;
    return r;
  endfunction

  // append one expected result at the tail
  function automatic void queue_expect(ptor_pkg::out_item_t r);
    expected_results.insert(expected_results.size(), r);
  endfunction

  // refresh a known address, else append, else overwrite the oldest
  function automatic ptor_pkg::status_e model_add(logic [31:0] addr, logic [15:0] port,
                                                  logic [31:0] now);
    int unsigned oldest;
    logic [31:0] least;
    oldest = 0;
    least  = 32'hFFFF_FFFF;
    if (port == 16'd0) return ptor_pkg::ST_IGNORED;
    for (int unsigned i = 0; i < fill_cnt; i++) begin
      if (peer_tab[i].addr == addr) begin
        peer_tab[i].port = port;
        peer_tab[i].seen = now;
        return ptor_pkg::ST_UPDATED;
      end
      if (peer_tab[i].seen < least) begin
        least  = peer_tab[i].seen;
        oldest = i;
      end
    end
    if (fill_cnt < DEPTH) begin
      peer_tab[fill_cnt] = '{addr: addr, port: port, seen: now};
      fill_cnt++;
      return ptor_pkg::ST_APPENDED;
    end
    peer_tab[oldest] = '{addr: addr, port: port, seen: now};
    return ptor_pkg::ST_REPLACED;
  endfunction

  // drop aged entries and compact in order (limit wraps mod 2^32)
  function automatic void prune_table(logic [31:0] now);
    logic [31:0] limit;
    int unsigned keep;
    limit = now - max_age_q;
    keep  = 0;
    for (int unsigned i = 0; i < fill_cnt; i++) begin
      if (peer_tab[i].seen >= limit) begin
        peer_tab[keep] = peer_tab[i];
        keep++;
      end
    end
    fill_cnt = keep;
  endfunction

  function automatic void predict_item(ptor_pkg::in_item_t it);
    int unsigned      mp, first, n, idx;
    ptor_pkg::entry_t none;
    none = '0;
    unique case (ptor_pkg::op_e'(it.op))
      ptor_pkg::OP_ADD: begin
        ptor_pkg::status_e st;
        st = model_add(it.peer_addr, it.peer_port, it.now_seconds);
        queue_expect(make_result(st, 1'b0, none, 1'b1));
      end
      ptor_pkg::OP_PRUNE: begin
        prune_table(it.now_seconds);
        queue_expect(make_result(ptor_pkg::ST_PRUNED, 1'b0, none, 1'b1));
      end
      ptor_pkg::OP_GET: begin
        mp = max_peers_q;
        if (mp < 1) mp = 1;
        if (mp > ptor_pkg::GET_LIMIT) mp = ptor_pkg::GET_LIMIT;
        if (fill_cnt == 0) begin
          queue_expect(make_result(ptor_pkg::ST_PEER, 1'b0, none, 1'b1));
        end else begin
          first = 0;
          n     = fill_cnt;
          if (fill_cnt > mp) begin
            first = (it.window_start < fill_cnt - mp - 1) ? it.window_start
                                                          : fill_cnt - mp - 1;
            n = mp;
          end
          for (int unsigned i = 0; i < n; i++) begin
            idx = first + i;
            if (idx >= DEPTH) idx = DEPTH - 1;
            queue_expect(make_result(ptor_pkg::ST_PEER, 1'b1, peer_tab[idx],
                                     i + 1 == n));
          end
        end
      end
      default: queue_expect(make_result(ptor_pkg::ST_IGNORED, 1'b0, none, 1'b1));
    endcase
  endfunction

  // watch config writes, accepted items and accepted results
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_cnt      = 0;
      max_peers_q   = 7'd30;
      max_age_q     = 32'd1800;
      fail_count_o  = 0;
      expected_results.delete();
      pending_o     = 0;
    end else begin
      ptor_pkg::out_item_t want;
      if (cfg_we_i) begin
        if (cfg_idx_i == ptor_pkg::CFG_MAX_PEERS) max_peers_q = cfg_data_i[6:0];
        else max_age_q = cfg_data_i;
      end
      if (in_valid_i && in_ready_i) predict_item(in_data_i);
      if (out_valid_i && out_ready_i) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result %h", $time, out_data_i);
          fail_count_o++;
        end else begin
          want = expected_results.pop_front();
          if (out_data_i !== want) begin
            $display("%0t: mismatch expected %h actual %h", $time, want, out_data_i);
            $display("  status %0d/%0d has %0d/%0d addr %h/%h port %h/%h cnt %0d/%0d last %0d/%0d",
                     want.status, out_data_i.status, want.has_peer, out_data_i.has_peer,
                     want.out_addr, out_data_i.out_addr, want.out_port, out_data_i.out_port,
                     want.entry_count, out_data_i.entry_count,
                     want.last_of_run, out_data_i.last_of_run);
            fail_count_o++;
          end
        end
      end
      pending_o = expected_results.size();
    end
  end

endmodule

// ----- tb/sv/tb_peer_table_oldest_replace.sv -----
module tb_peer_table_oldest_replace;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [0:0]  cfg_idx_i;
  logic [31:0] cfg_data_i;
  int          fail_count;
  int          pending;
  int          send_idle_pct;
  int          stall_pct;
  logic        squeeze_req;
  int          squeeze_cnt;
  logic [31:0] now_t;
  logic [31:0] salt;

  ptor_in_if  in_ch ();
  ptor_out_if out_ch ();

  peer_table_oldest_replace DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_if      (in_ch),
    .out_if     (out_ch)
  );

  ptor_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_ch.valid),
    .in_ready_i   (in_ch.ready),
    .in_data_i    (in_ch.data),
    .out_valid_i  (out_ch.valid),
    .out_ready_i  (out_ch.ready),
    .out_data_i   (out_ch.data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // overall time limit
  initial begin
    #50ms;
    $display("Regression FAIL");
    $finish;
  end

  // result side: random stalls plus one long hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
      squeeze_cnt  <= 0;
    end else if (squeeze_req && squeeze_cnt < 600) begin
      squeeze_cnt  <= squeeze_cnt + 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // offer one item, return at the edge it is taken
  task automatic send_item(ptor_pkg::op_e op, logic [31:0] addr, logic [15:0] port,
                           logic [31:0] now, logic [7:0] wstart);
    ptor_pkg::in_item_t it;
    it.op           = op;
    it.peer_addr    = addr;
    it.peer_port    = port;
    it.now_seconds  = now;
    it.window_start = wstart;
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= it;
    forever begin
      @(negedge clk_i);
      if (in_ch.ready) break;
    end
    @(posedge clk_i);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    forever begin
      @(negedge clk_i);
      if (pending == 0) break;
    end
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [31:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [31:0] peer_addr_of(int unsigned key);
    return (key * 32'h9E37_79B1) ^ salt;
  endfunction

  // mixed traffic over a pool of addresses with a slowly moving clock
  task automatic run_traffic(int n_items, int unsigned pool);
    int unsigned pick;
    for (int k = 0; k < n_items; k++) begin
      pick  = $urandom_range(99);
      now_t = now_t + $urandom_range(0, 12);
      if (pick < 68)
        send_item(ptor_pkg::OP_ADD, peer_addr_of($urandom_range(pool - 1)),
                  ($urandom_range(19) == 0) ? 16'd0 : 16'($urandom_range(1, 65535)),
                  now_t, 8'($urandom));
      else if (pick < 78)
        send_item(ptor_pkg::OP_PRUNE, $urandom, 16'($urandom), now_t, 8'($urandom));
      else if (pick < 96)
        send_item(ptor_pkg::OP_GET, $urandom, 16'($urandom), $urandom,
                  8'($urandom_range(0, 255)));
      else
        send_item(ptor_pkg::OP_NONE, $urandom, 16'($urandom), $urandom, 8'($urandom));
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = '0;
    cfg_data_i    = '0;
    in_ch.valid   = 1'b0;
    in_ch.data    = '0;
    send_idle_pct = 0;
    stall_pct     = 0;
    squeeze_req   = 1'b0;
    now_t         = $urandom;
    salt          = $urandom;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty table, ignored adds, extremes, updates, wrap
    send_item(ptor_pkg::OP_GET, 32'd0, 16'd0, 32'd0, 8'd0);
    send_item(ptor_pkg::OP_ADD, 32'h1234_5678, 16'd0, 32'd5, 8'd0);
    send_item(ptor_pkg::OP_NONE, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 8'hFF);
    send_item(ptor_pkg::OP_ADD, 32'h0000_0000, 16'hFFFF, 32'd0, 8'd0);
    send_item(ptor_pkg::OP_ADD, 32'hFFFF_FFFF, 16'd1, 32'hFFFF_FFFF, 8'hFF);
    send_item(ptor_pkg::OP_ADD, 32'hA5A5_5A5A, 16'h8000, 32'd100, 8'd0);
    send_item(ptor_pkg::OP_ADD, 32'h0000_0000, 16'h7FFF, 32'd200, 8'd0);
    send_item(ptor_pkg::OP_GET, 32'd0, 16'd0, 32'd0, 8'hFF);
    send_item(ptor_pkg::OP_PRUNE, 32'd0, 16'd0, 32'd100, 8'd0);
    send_item(ptor_pkg::OP_GET, 32'd0, 16'd0, 32'd0, 8'd0);
    drain();
    write_reg(ptor_pkg::CFG_MAX_PEERS, 32'd0);
    write_reg(ptor_pkg::CFG_MAX_AGE, 32'hFFFF_FFFF);
    send_item(ptor_pkg::OP_GET, 32'd0, 16'd0, 32'd0, 8'd0);
    send_item(ptor_pkg::OP_GET, 32'd0, 16'd0, 32'd0, 8'hFF);
    send_item(ptor_pkg::OP_PRUNE, 32'd0, 16'd0, 32'd0, 8'd0);
    send_item(ptor_pkg::OP_GET, 32'd0, 16'd0, 32'd0, 8'd1);
    drain();
    write_reg(ptor_pkg::CFG_MAX_PEERS, 32'h7F);
    write_reg(ptor_pkg::CFG_MAX_AGE, 32'd0);
    send_item(ptor_pkg::OP_GET, 32'd0, 16'd0, 32'd0, 8'd3);
    send_item(ptor_pkg::OP_PRUNE, 32'd0, 16'd0, 32'd150, 8'd0);
    send_item(ptor_pkg::OP_GET, 32'd0, 16'd0, 32'd0, 8'd0);

    // random phases, one idling style each
    for (int ph = 0; ph < 4; ph++) begin
      drain();
      case (ph)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 69; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 69; end
        default: begin send_idle_pct = 9; stall_pct = 9; end
      endcase
      case (ph)
        0: write_reg(ptor_pkg::CFG_MAX_PEERS, 32'd64);
        1: write_reg(ptor_pkg::CFG_MAX_PEERS, 32'd1);
        default: write_reg(ptor_pkg::CFG_MAX_PEERS, $urandom_range(0, 127));
      endcase
      write_reg(ptor_pkg::CFG_MAX_AGE, (ph == 0) ? 32'hFFFF_FFFF : $urandom_range(40, 900));
      if (ph == 0) begin
        squeeze_req = 1'b1;
        run_traffic(110, 220);
      end else begin
        run_traffic(69, 200);
      end
    end

    // full table with every time at the maximum: tie goes to entry 0
    drain();
    send_idle_pct = 0;
    stall_pct     = 30;
    write_reg(ptor_pkg::CFG_MAX_AGE, 32'd0);
    send_item(ptor_pkg::OP_PRUNE, 32'd0, 16'd0, 32'hFFFF_FFFF, 8'd0);
    salt = ~salt;
    for (int k = 0; k < 131; k++)
      send_item(ptor_pkg::OP_ADD, peer_addr_of(k + 1000), 16'($urandom_range(1, 65535)),
                32'hFFFF_FFFF, 8'd0);
    drain();
    write_reg(ptor_pkg::CFG_MAX_PEERS, 32'd30);
    send_item(ptor_pkg::OP_GET, 32'd0, 16'd0, 32'd0, 8'hFF);
    send_item(ptor_pkg::OP_GET, 32'd0, 16'd0, 32'd0, 8'd40);
    send_item(ptor_pkg::OP_PRUNE, 32'd0, 16'd0, 32'd7, 8'd0);
    send_item(ptor_pkg::OP_GET, 32'd0, 16'd0, 32'd0, 8'd0);

    drain();
    repeat (200) @(posedge clk_i);
    if (fail_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
